[hw/rtl/mmpp_pkg.sv]
// Package for the min/max peak pyramid: request and result types,
// widths and pyramid constants. No dependencies.
`timescale 1ns / 1ps

package mmpp_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned INDEX_BITS  = 17;
  localparam int unsigned LEVEL_BITS  = 2;
  localparam int unsigned NUM_LEVELS  = 3;
  localparam int unsigned MAX_RESULTS = 6;
  localparam int unsigned COUNT_BITS  = 3;
  localparam int unsigned SLOT_BITS   = 3;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [INDEX_BITS-1:0]         index_t;
  typedef logic [COUNT_BITS-1:0]         count_t;

  typedef struct packed {
    sample_t sample_left;
    sample_t sample_right;
    logic    final_frame;
  } in_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] level;
    index_t                entry_index;
    sample_t               min_left;
    sample_t               max_left;
    sample_t               min_right;
    sample_t               max_right;
    logic                  last_of_run;
  } out_t;

  typedef struct packed {
    sample_t min_l;
    sample_t max_l;
    sample_t min_r;
    sample_t max_r;
  } run_t;

  typedef struct packed {
    out_t [MAX_RESULTS-1:0] entry;
    count_t                 count;
  } res_set_t;

endpackage

[hw/rtl/mmpp_core.sv]
// Pyramid state and single-pass update: folds one request into the three
// levels and lists the entries it completes. Depends on mmpp_pkg.
`timescale 1ns / 1ps

module mmpp_core #(
  parameter int unsigned BLOCK_SIZE = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  mmpp_pkg::in_t     item_i,
  input  logic              stereo_i,
  output mmpp_pkg::res_set_t res_o
);

  localparam int unsigned FillW = $clog2(BLOCK_SIZE);
  localparam logic [FillW-1:0] FillLast = FillW'(BLOCK_SIZE - 1);
  localparam int unsigned NL = mmpp_pkg::NUM_LEVELS;

  mmpp_pkg::run_t   run_q  [NL];
  logic [FillW-1:0] fill_q [NL];
  mmpp_pkg::index_t idx_q  [NL];

  mmpp_pkg::run_t   smp;
  mmpp_pkg::run_t   s_d    [NL];
  mmpp_pkg::run_t   f_d    [NL];
  logic [FillW-1:0] fill_d [NL];
  mmpp_pkg::index_t idx_d  [NL];
  logic             full   [NL];
  mmpp_pkg::out_t   reg_e  [NL];
  mmpp_pkg::out_t   fin_e  [NL];
  mmpp_pkg::count_t n_reg;
  mmpp_pkg::count_t n_tot;

  function automatic mmpp_pkg::run_t absorb(mmpp_pkg::run_t cur, logic open,
                                            mmpp_pkg::run_t x);
    mmpp_pkg::run_t r;
    r = cur;
    if (open) begin
      r = x;
    end else begin
      if (x.min_l < cur.min_l) r.min_l = x.min_l;
      if (x.max_l > cur.max_l) r.max_l = x.max_l;
      if (x.min_r < cur.min_r) r.min_r = x.min_r;
      if (x.max_r > cur.max_r) r.max_r = x.max_r;
    end
    return r;
  endfunction

  function automatic mmpp_pkg::out_t make_entry(logic [mmpp_pkg::LEVEL_BITS-1:0] lvl,
                                                mmpp_pkg::index_t idx,
                                                mmpp_pkg::run_t v, logic st);
    mmpp_pkg::out_t e;
    e.level       = lvl;
    e.entry_index = idx;
    e.min_left    = v.min_l;
    e.max_left    = v.max_l;
    e.min_right   = st ? v.min_r : '0;
    e.max_right   = st ? v.max_r : '0;
    e.last_of_run = 1'b0;
    return e;
  endfunction

  always_comb begin
    smp.min_l = item_i.sample_left;
    smp.max_l = item_i.sample_left;
    smp.min_r = item_i.sample_right;
    smp.max_r = item_i.sample_right;

    // regular entries: level 0 first, carry upward while blocks fill
    full[0]   = (fill_q[0] == FillLast);
    s_d[0]    = absorb(run_q[0], fill_q[0] == '0, smp);
    fill_d[0] = full[0] ? '0 : fill_q[0] + 1'b1;
    for (int lvl = 1; lvl < NL; lvl++) begin
      full[lvl] = full[lvl-1] && (fill_q[lvl] == FillLast);
      s_d[lvl]  = full[lvl-1] ? absorb(run_q[lvl], fill_q[lvl] == '0, s_d[lvl-1])
                              : run_q[lvl];
      if (full[lvl]) begin
        fill_d[lvl] = '0;
      end else if (full[lvl-1]) begin
        fill_d[lvl] = fill_q[lvl] + 1'b1;
      end else begin
        fill_d[lvl] = fill_q[lvl];
      end
    end

    // flush entries: an empty level-0 block closes as all zero
    f_d[0] = (fill_d[0] == '0) ? '0 : s_d[0];
    for (int lvl = 1; lvl < NL; lvl++) begin
      f_d[lvl] = absorb(s_d[lvl], fill_d[lvl] == '0, f_d[lvl-1]);
    end

    n_reg = '0;
    for (int lvl = 0; lvl < NL; lvl++) begin
      idx_d[lvl] = idx_q[lvl] + mmpp_pkg::INDEX_BITS'(full[lvl]);
      n_reg      = n_reg + mmpp_pkg::COUNT_BITS'(full[lvl]);
      reg_e[lvl] = make_entry(mmpp_pkg::LEVEL_BITS'(lvl), idx_q[lvl], s_d[lvl], stereo_i);
      fin_e[lvl] = make_entry(mmpp_pkg::LEVEL_BITS'(lvl), idx_d[lvl], f_d[lvl], stereo_i);
    end
    n_tot = item_i.final_frame ? n_reg + mmpp_pkg::COUNT_BITS'(NL) : n_reg;

    res_o.count = n_tot;
    for (int k = 0; k < mmpp_pkg::MAX_RESULTS; k++) begin
      res_o.entry[k] = '0;
      for (int lvl = 0; lvl < NL; lvl++) begin
        if ((k == lvl) && (mmpp_pkg::COUNT_BITS'(lvl) < n_reg)) begin
          res_o.entry[k] = reg_e[lvl];
        end
        if (item_i.final_frame
            && (mmpp_pkg::COUNT_BITS'(k) == n_reg + mmpp_pkg::COUNT_BITS'(lvl))) begin
          res_o.entry[k] = fin_e[lvl];
        end
      end
      res_o.entry[k].last_of_run = (mmpp_pkg::COUNT_BITS'(k) + 1'b1 == n_tot);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int lvl = 0; lvl < NL; lvl++) begin
        run_q[lvl]  <= '0;
        fill_q[lvl] <= '0;
        idx_q[lvl]  <= '0;
      end
    end else if (fire_i) begin
      for (int lvl = 0; lvl < NL; lvl++) begin
        if (item_i.final_frame) begin
          run_q[lvl]  <= '0;
          fill_q[lvl] <= '0;
          idx_q[lvl]  <= '0;
        end else begin
          run_q[lvl]  <= s_d[lvl];
          fill_q[lvl] <= fill_d[lvl];
          idx_q[lvl]  <= idx_d[lvl];
        end
      end
    end
  end

endmodule

[hw/rtl/mmpp_res_queue.sv]
// Result register bank: holds the entries of one request and drains them
// one per cycle, while out_stall_i is low, onto the output channel. Depends on mmpp_pkg.
`timescale 1ns / 1ps

module mmpp_res_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  mmpp_pkg::res_set_t res_i,
  output logic               ready_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mmpp_pkg::out_t     out_data_o
);

  mmpp_pkg::out_t   slot_q [mmpp_pkg::MAX_RESULTS];
  mmpp_pkg::count_t count_q;
  logic [mmpp_pkg::SLOT_BITS-1:0] rd_q;
  logic pop;

  assign out_valid_o = (count_q != '0);
  assign out_data_o  = slot_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign ready_o     = (count_q == '0) || ((count_q == mmpp_pkg::COUNT_BITS'(1)) && pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      rd_q    <= '0;
    end else if (load_i) begin
      count_q <= res_i.count;
      rd_q    <= '0;
    end else if (pop) begin
      count_q <= count_q - 1'b1;
      rd_q    <= rd_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int k = 0; k < mmpp_pkg::MAX_RESULTS; k++) begin
        slot_q[k] <= res_i.entry[k];
      end
    end
  end

endmodule

[hw/rtl/min_max_peak_pyramid.sv]
// Top level of the min/max peak pyramid: request register, mode register,
// pyramid core and result bank. Depends on mmpp_pkg, mmpp_core, mmpp_res_queue.
//
// Usage: frames enter on in_valid_i/in_data_i and are taken when in_stall_o
// is low. Overview entries leave on out_valid_o/out_data_o and are taken
// when out_stall_i is low. cfg_we_i/cfg_wdata_i set the stereo mode.
// Order: a taken frame is held in the request register; once the bank has
// room it is folded into the pyramid and its entries are loaded into the
// result bank, from which its first entry is offered.
// Throughput: one frame per cycle while each frame yields at most one entry
// and out_stall_i is low; a frame that yields more entries (up to six on the
// last frame) holds the result bank until they drain, one entry per cycle while out_stall_i is low.
// Reset: all levels empty, indices zero, mono mode.
// Stall: a stalled output holds its entry; the request register then fills
// and in_stall_o rises until the bank has room.
`timescale 1ns / 1ps

module min_max_peak_pyramid #(
  parameter int unsigned BLOCK_SIZE = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mmpp_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mmpp_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i
);

  logic               in_vld_q;
  mmpp_pkg::in_t      in_q;
  logic               stereo_q;
  logic               bank_ready;
  logic               fire;
  mmpp_pkg::res_set_t res_set;

  assign fire       = in_vld_q && bank_ready;
  assign in_stall_o = in_vld_q && !bank_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      stereo_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      if (cfg_we_i) begin
        stereo_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  mmpp_core #(
    .BLOCK_SIZE(BLOCK_SIZE)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .item_i  (in_q),
    .stereo_i(stereo_q),
    .res_o   (res_set)
  );

  mmpp_res_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (fire),
    .res_i      (res_set),
    .ready_o    (bank_ready),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
